FILE: hw/rtl/smm_pkg.sv
// shared types and constants for the square matrix multiplier
// no dependencies; imported by the controller, datapath and top level
package smm_pkg;

    localparam int MAX_N  = 8;
    localparam int IDX_W  = 3;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = MAX_N * MAX_N;
    localparam int DATA_W = 32;
    localparam int SIZE_W = 4;

    typedef enum logic [1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_COMPUTE = 2'd2
    } opcode_t;

    typedef struct packed {
        opcode_t                    opcode;
        logic [IDX_W-1:0]           row_index;
        logic [IDX_W-1:0]           col_index;
        logic signed [DATA_W-1:0]   element_value;
    } in_word_t;

    typedef struct packed {
        logic [IDX_W-1:0]           out_row;
        logic [IDX_W-1:0]           out_col;
        logic signed [DATA_W-1:0]   product_value;
        logic                       last_element;
    } out_word_t;

    // tag that travels with each multiply-accumulate step
    typedef struct packed {
        logic                       first_k;
        logic                       last_k;
        logic [IDX_W-1:0]           row;
        logic [IDX_W-1:0]           col;
        logic                       last_element;
    } mac_tag_t;

    typedef struct packed {
        logic                       wr_a;
        logic                       wr_b;
        logic [ADDR_W-1:0]          wr_addr;
        logic [DATA_W-1:0]          wr_data;
        logic                       rd_en;
        logic [ADDR_W-1:0]          rd_addr_a;
        logic [ADDR_W-1:0]          rd_addr_b;
        mac_tag_t                   tag;
    } dp_cmd_t;

    typedef struct packed {
        logic                       pipe_busy;
    } dp_status_t;

endpackage

FILE: hw/rtl/square_matrix_multiply.sv
// square integer matrix multiplier, top level
// depends on smm_pkg, smm_controller and smm_datapath
// loads may follow back to back
// compute: every product term passes through the single multiply-accumulate, then the pipeline drains
// result words come out in row-major order, one for each element of the product
// rst_n is asynchronous: idle, size 8; store contents are kept, results cannot be stalled
module square_matrix_multiply
    import smm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  in_word_t            in_word,
    input  logic                size_we,
    input  logic [SIZE_W-1:0]   size_data,
    output logic                result_valid,
    output out_word_t           result_word
);

    // controller sequences loads and the i/j/k loop, datapath does the math
    dp_cmd_t    cmd;
    dp_status_t status;

    smm_controller u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .in_word    (in_word),
        .size_we    (size_we),
        .size_data  (size_data),
        .cmd        (cmd),
        .status     (status)
    );

    // read, multiply, accumulate: three register stages after each command
    smm_datapath u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .result_valid   (result_valid),
        .result_word    (result_word)
    );

`ifndef SYNTHESIS
    // results only ever come out while a compute is running or draining
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result word outside a compute run");

    // the final word of a run is not directly followed by another word
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_word.last_element) |=> !result_valid)
        else $error("result word after the last element");

    // an accepted compute word starts a run
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && in_word.opcode == OP_COMPUTE) |=> busy)
        else $error("compute word did not start a run");
`endif

endmodule

FILE: hw/rtl/smm_controller.sv
// sequencer for loads and the i/j/k product loop, holds the size register
// depends on smm_pkg; drives smm_datapath through dp_cmd_t
module smm_controller
    import smm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  in_word_t            in_word,
    input  logic                size_we,
    input  logic [SIZE_W-1:0]   size_data,
    output dp_cmd_t             cmd,
    input  dp_status_t          status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    state_t             state_reg, state_next;
    dp_cmd_t            cmd_reg, cmd_next;
    logic [SIZE_W-1:0]  size_reg;
    logic [IDX_W-1:0]   n_last_reg, n_last_next;
    logic [IDX_W-1:0]   i_reg, i_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [IDX_W-1:0]   size_last;
    logic [SIZE_W-1:0]  size_dec;

    // clamp the configured size into 1..MAX_N, kept as last index
    always_comb
    begin
        size_dec = size_reg - SIZE_W'(1);
        if (size_reg == '0)
            size_last = '0;
        else if (size_reg > SIZE_W'(MAX_N))
            size_last = IDX_W'(MAX_N - 1);
        else
            size_last = size_dec[IDX_W-1:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = '0;
        n_last_next = n_last_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (in_word.opcode)
                        OP_LOAD_A, OP_LOAD_B:
                        begin
                            cmd_next.wr_a    = (in_word.opcode == OP_LOAD_A);
                            cmd_next.wr_b    = (in_word.opcode == OP_LOAD_B);
                            cmd_next.wr_addr = {in_word.row_index, in_word.col_index};
                            cmd_next.wr_data = in_word.element_value;
                        end
                        OP_COMPUTE:
                        begin
                            n_last_next = size_last;
                            i_next      = '0;
                            j_next      = '0;
                            k_next      = '0;
                            state_next  = ST_RUN;
                        end
                        default:
                        begin
                            cmd_next = '0;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                cmd_next.rd_en            = 1'b1;
                cmd_next.rd_addr_a        = {i_reg, k_reg};
                cmd_next.rd_addr_b        = {k_reg, j_reg};
                cmd_next.tag.first_k      = (k_reg == '0);
                cmd_next.tag.last_k       = (k_reg == n_last_reg);
                cmd_next.tag.row          = i_reg;
                cmd_next.tag.col          = j_reg;
                cmd_next.tag.last_element = (i_reg == n_last_reg) && (j_reg == n_last_reg);
                if (k_reg != n_last_reg)
                    k_next = k_reg + IDX_W'(1);
                else
                begin
                    k_next = '0;
                    if (j_reg != n_last_reg)
                        j_next = j_reg + IDX_W'(1);
                    else
                    begin
                        j_next = '0;
                        if (i_reg != n_last_reg)
                            i_next = i_reg + IDX_W'(1);
                        else
                            state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!cmd_reg.rd_en && !status.pipe_busy)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cmd_reg    <= '0;
            size_reg   <= SIZE_W'(MAX_N);
            n_last_reg <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cmd_reg    <= cmd_next;
            n_last_reg <= n_last_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            if (size_we)
                size_reg <= size_data;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign cmd  = cmd_reg;

endmodule

FILE: hw/rtl/smm_datapath.sv
// matrix stores, multiplier and accumulator with the result register
// depends on smm_pkg; commanded by smm_controller
module smm_datapath
    import smm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    output logic        result_valid,
    output out_word_t   result_word
);

    logic [DATA_W-1:0]      mem_a [DEPTH];
    logic [DATA_W-1:0]      mem_b [DEPTH];
    logic [DATA_W-1:0]      rd_a_reg;
    logic [DATA_W-1:0]      rd_b_reg;
    logic                   s1_valid_reg;
    mac_tag_t               s1_tag_reg;
    logic                   s2_valid_reg;
    mac_tag_t               s2_tag_reg;
    logic [DATA_W-1:0]      prod_reg;
    logic [2*DATA_W-1:0]    prod_full;
    logic [DATA_W-1:0]      acc_reg;
    logic [DATA_W-1:0]      acc_next;
    logic                   out_valid_reg;
    out_word_t              out_word_reg;

    // stores: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_a)
            mem_a[cmd.wr_addr] <= cmd.wr_data;
        if (cmd.wr_b)
            mem_b[cmd.wr_addr] <= cmd.wr_data;
        rd_a_reg <= mem_a[cmd.rd_addr_a];
        rd_b_reg <= mem_b[cmd.rd_addr_b];
    end

    // low half of the product is all that survives the wrap
    assign prod_full = rd_a_reg * rd_b_reg;
    assign acc_next  = s2_tag_reg.first_k ? prod_reg : acc_reg + prod_reg;

    always_ff @(posedge clk)
    begin
        s1_tag_reg <= cmd.tag;
        s2_tag_reg <= s1_tag_reg;
        prod_reg   <= prod_full[DATA_W-1:0];
        if (s2_valid_reg)
            acc_reg <= acc_next;
        out_word_reg.out_row       <= s2_tag_reg.row;
        out_word_reg.out_col       <= s2_tag_reg.col;
        out_word_reg.product_value <= acc_next;
        out_word_reg.last_element  <= s2_tag_reg.last_element;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= cmd.rd_en;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg && s2_tag_reg.last_k;
        end
    end

    assign status.pipe_busy = s1_valid_reg || s2_valid_reg;
    assign result_valid     = out_valid_reg;
    assign result_word      = out_word_reg;

endmodule
